// ===== rtl/pit_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pit_pkg
// Shared constants for the point-in-tetrahedron test: field widths, register
// indexes and parameter defaults.
// ----------------------------------------------------------------------------
package pit_pkg;

    localparam int COORD_BITS_DEF = 16;   // default coordinate width
    localparam int LANE_W         = 16;   // one coordinate lane in a packed vertex
    localparam int VERT_W         = 3 * LANE_W;
    localparam int TOL_W          = 16;   // Q0.16 tolerance
    localparam int LIMIT_W        = 51;
    localparam int VOL_W          = 51;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 51;
    localparam int IN_DATA_W      = 48;   // x, y, z
    localparam int OUT_DATA_W     = 56;   // inside, degenerate, volume, padding
    localparam int STAGES         = 7;

    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_ZERO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_THREE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEGEN_LIMIT  = 3'd5;

endpackage
`default_nettype wire

// ===== rtl/pit_cross.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pit_cross
// One registered cross product b x c of two signed 3-vectors.
// ----------------------------------------------------------------------------
module pit_cross #(
    parameter int IN_W = pit_pkg::COORD_BITS_DEF + 1
) (
    input  wire logic                  clk,
    input  wire logic                  load,
    input  wire logic signed [IN_W-1:0] b [3],
    input  wire logic signed [IN_W-1:0] c [3],
    output logic signed [2*IN_W:0]      prod_vec_reg [3]
);

    localparam int PROD_W = 2 * IN_W;
    localparam int OUT_W  = 2 * IN_W + 1;

    logic signed [PROD_W-1:0] pa [3];
    logic signed [PROD_W-1:0] pb [3];
    logic signed [OUT_W-1:0]  prod_vec_next [3];

    // component k = b[k+1]*c[k+2] - b[k+2]*c[k+1]
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pa[k] = b[(k + 1) % 3] * c[(k + 2) % 3];
            pb[k] = b[(k + 2) % 3] * c[(k + 1) % 3];
            prod_vec_next[k] = OUT_W'(pa[k]) - OUT_W'(pb[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_vec_reg[k] <= prod_vec_next[k];
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/point_in_tetrahedron_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// point_in_tetrahedron_test
// Barycentric containment test of a point stream against one tetrahedron.
// ----------------------------------------------------------------------------
// Vertices, tolerance and the degenerate limit are for the user to write
// through the cfg port while no item is in flight; the block does not
// enforce this. Each point item gives one result item; a new item is taken
// every cycle unless back-pressure has filled the stages. The exact integer
// datapath gives edge vectors, cross products, triple-product terms, their
// sum, sign fix, tolerance partial products and the final compares one
// register stage each. Every stage has its own valid bit and only holds
// when the stage after it is full and stalled, so bubbles are squeezed out
// and an item is still taken while a finished result waits at the output.
// ----------------------------------------------------------------------------
module point_in_tetrahedron_test #(
    parameter int COORD_BITS = pit_pkg::COORD_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [pit_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pit_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [15:0] point_x, [31:16] point_y, [47:32] point_z
    input  wire logic [pit_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [0] inside_res, [1] degenerate, [52:2] volume_six, [55:53] zero
    output logic [pit_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

    localparam int NS      = pit_pkg::STAGES;
    localparam int LANE_W  = pit_pkg::LANE_W;
    localparam int TOL_W   = pit_pkg::TOL_W;
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int CROSS_W = 2 * DIFF_W + 1;
    localparam int TP_W    = DIFF_W + CROSS_W;
    localparam int TRI_W   = TP_W + 2;
    localparam int LO_W    = TRI_W / 2;
    localparam int HI_W    = TRI_W - LO_W;
    localparam int RHS_W   = TRI_W + TOL_W;
    localparam int CMP_W   = (TRI_W > pit_pkg::LIMIT_W) ? TRI_W : pit_pkg::LIMIT_W;
    localparam int VOL_W   = pit_pkg::VOL_W;
    localparam int PAD_W   = pit_pkg::OUT_DATA_W - VOL_W - 2;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [pit_pkg::VERT_W-1:0]  vert_reg [4];
    logic [TOL_W-1:0]            tol_reg;
    logic [pit_pkg::LIMIT_W-1:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                vert_reg[i] <= '0;
            end
            tol_reg   <= '0;
            limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pit_pkg::REG_VERTEX_ZERO:  vert_reg[0] <= cfg_data[pit_pkg::VERT_W-1:0];
                pit_pkg::REG_VERTEX_ONE:   vert_reg[1] <= cfg_data[pit_pkg::VERT_W-1:0];
                pit_pkg::REG_VERTEX_TWO:   vert_reg[2] <= cfg_data[pit_pkg::VERT_W-1:0];
                pit_pkg::REG_VERTEX_THREE: vert_reg[3] <= cfg_data[pit_pkg::VERT_W-1:0];
                pit_pkg::REG_TOLERANCE:    tol_reg     <= cfg_data[TOL_W-1:0];
                pit_pkg::REG_DEGEN_LIMIT:  limit_reg   <= cfg_data[pit_pkg::LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage flow control: a stage loads when it is empty or moves on
    // ------------------------------------------------------------------
    logic [NS:1]   valid_reg;
    logic [NS+1:1] adv;

    always_comb
    begin
        adv[NS+1] = m_axis_tready;
        for (int k = NS; k >= 1; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                valid_reg[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= NS; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_axis_tready = adv[1];
    assign m_axis_tvalid = valid_reg[NS];

    // ------------------------------------------------------------------
    // stage 1: edge vectors and point-relative vectors
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0] vtx [4][3];
    logic signed [DIFF_W-1:0] pnt [3];
    logic signed [DIFF_W-1:0] e1_reg [3];
    logic signed [DIFF_W-1:0] e2_reg [3];
    logic signed [DIFF_W-1:0] e3_reg [3];
    logic signed [DIFF_W-1:0] q_reg  [3];
    logic signed [DIFF_W-1:0] r1_reg [3];
    logic signed [DIFF_W-1:0] r2_reg [3];
    logic signed [DIFF_W-1:0] r3_reg [3];

    // lanes keep only the low COORD_BITS bits, sign-extended
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                vtx[i][k] = DIFF_W'($signed(vert_reg[i][LANE_W*k +: COORD_BITS]));
            end
            pnt[k] = DIFF_W'($signed(s_axis_tdata[LANE_W*k +: COORD_BITS]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                e1_reg[k] <= vtx[1][k] - vtx[0][k];
                e2_reg[k] <= vtx[2][k] - vtx[0][k];
                e3_reg[k] <= vtx[3][k] - vtx[0][k];
                q_reg[k]  <= pnt[k] - vtx[0][k];
                r1_reg[k] <= vtx[1][k] - pnt[k];
                r2_reg[k] <= vtx[2][k] - pnt[k];
                r3_reg[k] <= vtx[3][k] - pnt[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 2: cross products
    // ------------------------------------------------------------------
    logic signed [CROSS_W-1:0] c23_reg [3];   // e2 x e3
    logic signed [CROSS_W-1:0] cq3_reg [3];   // q x e3
    logic signed [CROSS_W-1:0] c2q_reg [3];   // e2 x q
    logic signed [CROSS_W-1:0] crr_reg [3];   // r2 x r3
    logic signed [DIFF_W-1:0]  e1_s2_reg [3];
    logic signed [DIFF_W-1:0]  q_s2_reg  [3];
    logic signed [DIFF_W-1:0]  r1_s2_reg [3];

    pit_cross #(.IN_W(DIFF_W)) u_cross_23 (
        .clk          (clk),
        .load         (adv[2]),
        .b            (e2_reg),
        .c            (e3_reg),
        .prod_vec_reg (c23_reg)
    );

    pit_cross #(.IN_W(DIFF_W)) u_cross_q3 (
        .clk          (clk),
        .load         (adv[2]),
        .b            (q_reg),
        .c            (e3_reg),
        .prod_vec_reg (cq3_reg)
    );

    pit_cross #(.IN_W(DIFF_W)) u_cross_2q (
        .clk          (clk),
        .load         (adv[2]),
        .b            (e2_reg),
        .c            (q_reg),
        .prod_vec_reg (c2q_reg)
    );

    pit_cross #(.IN_W(DIFF_W)) u_cross_rr (
        .clk          (clk),
        .load         (adv[2]),
        .b            (r2_reg),
        .c            (r3_reg),
        .prod_vec_reg (crr_reg)
    );

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int k = 0; k < 3; k++)
            begin
                e1_s2_reg[k] <= e1_reg[k];
                q_s2_reg[k]  <= q_reg[k];
                r1_s2_reg[k] <= r1_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 3: dot-product terms; order is D, Nu, Nv, Nw, N0
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0]  dot_a [5][3];
    logic signed [CROSS_W-1:0] dot_b [5][3];
    logic signed [TP_W-1:0]    term_reg [5][3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dot_a[0][k] = e1_s2_reg[k];  dot_b[0][k] = c23_reg[k];
            dot_a[1][k] = q_s2_reg[k];   dot_b[1][k] = c23_reg[k];
            dot_a[2][k] = e1_s2_reg[k];  dot_b[2][k] = cq3_reg[k];
            dot_a[3][k] = e1_s2_reg[k];  dot_b[3][k] = c2q_reg[k];
            dot_a[4][k] = r1_s2_reg[k];  dot_b[4][k] = crr_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            for (int j = 0; j < 5; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    term_reg[j][k] <= TP_W'(dot_a[j][k]) * TP_W'(dot_b[j][k]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 4: triple products
    // ------------------------------------------------------------------
    logic signed [TRI_W-1:0] tri_reg [5];

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            for (int j = 0; j < 5; j++)
            begin
                tri_reg[j] <= TRI_W'(term_reg[j][0]) + TRI_W'(term_reg[j][1])
                              + TRI_W'(term_reg[j][2]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 5: make D positive, flip numerators with it, coplanar check
    // ------------------------------------------------------------------
    logic signed [TRI_W-1:0] fix_reg [5];
    logic                    degen_s5_reg;
    logic signed [TRI_W-1:0] fix_next [5];
    logic [CMP_W-1:0]        d_abs_ext;

    always_comb
    begin
        for (int j = 0; j < 5; j++)
        begin
            fix_next[j] = tri_reg[0][TRI_W-1] ? -tri_reg[j] : tri_reg[j];
        end
        d_abs_ext = CMP_W'($unsigned(fix_next[0]));
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            for (int j = 0; j < 5; j++)
            begin
                fix_reg[j] <= fix_next[j];
            end
            degen_s5_reg <= d_abs_ext <= CMP_W'(limit_reg);
        end
    end

    // ------------------------------------------------------------------
    // stage 6: D * tolerance in two partial products, numerator magnitudes
    // ------------------------------------------------------------------
    logic [LO_W+TOL_W-1:0] plo_reg;
    logic [HI_W+TOL_W-1:0] phi_reg;
    logic [TRI_W-1:0]      mag_reg [4];
    logic [3:0]            neg_reg;
    logic [TRI_W-1:0]      d_abs_reg;
    logic                  degen_s6_reg;
    logic [TRI_W-1:0]      d_u;

    assign d_u = $unsigned(fix_reg[0]);

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            plo_reg <= (LO_W+TOL_W)'(d_u[LO_W-1:0]) * (LO_W+TOL_W)'(tol_reg);
            phi_reg <= (HI_W+TOL_W)'(d_u[TRI_W-1:LO_W]) * (HI_W+TOL_W)'(tol_reg);
            for (int j = 0; j < 4; j++)
            begin
                neg_reg[j] <= fix_reg[j+1][TRI_W-1];
                mag_reg[j] <= $unsigned(-fix_reg[j+1]);
            end
            d_abs_reg    <= d_u;
            degen_s6_reg <= degen_s5_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: |N| * 2^16 <= D * tolerance for each negative numerator
    // ------------------------------------------------------------------
    logic [RHS_W-1:0] rhs;
    logic [3:0]       coord_ok;
    logic             inside_reg;
    logic             degen_reg;
    logic [VOL_W-1:0] vol_reg;
    logic [CMP_W-1:0] d_abs_out;

    always_comb
    begin
        rhs = (RHS_W'(phi_reg) << LO_W) + RHS_W'(plo_reg);
        for (int j = 0; j < 4; j++)
        begin
            coord_ok[j] = !neg_reg[j] || ((RHS_W'(mag_reg[j]) << TOL_W) <= rhs);
        end
        d_abs_out = CMP_W'(d_abs_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            inside_reg <= !degen_s6_reg && (&coord_ok);
            degen_reg  <= degen_s6_reg;
            vol_reg    <= d_abs_out[VOL_W-1:0];
        end
    end

    assign m_axis_tdata = {{PAD_W{1'b0}}, vol_reg, degen_reg, inside_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_degen_not_inside: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(inside_reg && degen_reg))
        else $error("inside reported for degenerate tetrahedron");

    a_zero_vol_degen: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && vol_reg == '0) |-> degen_reg)
        else $error("zero volume not flagged degenerate");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> valid_reg[1])
        else $error("accepted item lost at first stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[3] && !adv[4]) |=> valid_reg[3])
        else $error("stalled item dropped in pipeline");

    a_drain_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NS-1] && adv[NS]) |=> valid_reg[NS])
        else $error("item lost entering output stage");

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-tetrahedron test bench
// Drives point items through the stream port under a range of register
// setups, with random back-pressure and gaps, and compares each result item
// with a scripted verdict or the exact integer barycentric prediction here.
// ----------------------------------------------------------------------------
module testbench;

    localparam int COORD_BITS  = pit_pkg::COORD_BITS_DEF;
    localparam int LANE_W      = pit_pkg::LANE_W;
    localparam int VERT_W      = pit_pkg::VERT_W;
    localparam int TOL_W       = pit_pkg::TOL_W;
    localparam int LIMIT_W     = pit_pkg::LIMIT_W;
    localparam int VOL_W       = pit_pkg::VOL_W;
    localparam int CFG_IDX_W   = pit_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = pit_pkg::CFG_DATA_W;
    localparam int IN_DATA_W   = pit_pkg::IN_DATA_W;
    localparam int OUT_DATA_W  = pit_pkg::OUT_DATA_W;
    localparam int STAGES      = pit_pkg::STAGES;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES = 8;
    localparam int BATCHES = 5;
    localparam int BATCH_ITEMS = 50;

    // index codes the block decodes to nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [VOL_W-1:0] UNIT_VOL  = 51'd1073741824;
    localparam logic [VOL_W-1:0] WIDE_VOL  = 51'd281462092005375;
    localparam logic [VOL_W-1:0] LIMIT_MAX = 51'd1688772552032250;

    typedef struct packed {
        longint x;
        longint y;
        longint z;
    } vec3_t;

    typedef struct packed {
        logic             in_tet;
        logic             degen;
        logic [VOL_W-1:0] volume;
    } verdict_t;

    typedef struct packed {
        bit       known;
        verdict_t v;
    } answer_t;

    typedef enum {ROW_WRITE, ROW_POINT} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [IN_DATA_W-1:0]  pt;
        bit                    known;
        verdict_t              v;
    } row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    // register copy used by the predictor
    logic [VERT_W-1:0]  vtx_reg [4];
    logic [TOL_W-1:0]   tol_reg;
    logic [LIMIT_W-1:0] limit_reg;

    answer_t  given_answers [$];
    verdict_t expected_verdicts [$];
    row_t     script [$];

    int  mismatches = 0;
    int  quiet_cycles = 0;
    int  points_sent = 0;
    int  writes_done = 0;
    int  inside_seen = 0;
    int  degen_seen = 0;
    int  sender_idle = 0;
    int  stall_pct = 0;
    bit  hold_toggle = 1'b0;
    bit  hold_seen = 1'b0;
    int  hold_left = 0;

    point_in_tetrahedron_test #(
        .COORD_BITS(COORD_BITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic longint coord_of(logic [LANE_W-1:0] raw);
        logic [LANE_W-1:0] m;
        m = raw & LANE_W'((32'd1 << COORD_BITS) - 1);
        if (m[COORD_BITS-1])
            return longint'(m) - (longint'(1) << COORD_BITS);
        return longint'(m);
    endfunction

    function automatic vec3_t vertex_of(logic [VERT_W-1:0] word);
        vec3_t r;
        r.x = coord_of(word[15:0]);
        r.y = coord_of(word[31:16]);
        r.z = coord_of(word[47:32]);
        return r;
    endfunction

    function automatic vec3_t vsub(vec3_t a, vec3_t b);
        vec3_t r;
        r.x = a.x - b.x;
        r.y = a.y - b.y;
        r.z = a.z - b.z;
        return r;
    endfunction

    function automatic longint triple(vec3_t a, vec3_t b, vec3_t c);
        longint cx;
        longint cy;
        longint cz;
        cx = b.y * c.z - b.z * c.y;
        cy = b.z * c.x - b.x * c.z;
        cz = b.x * c.y - b.y * c.x;
        return a.x * cx + a.y * cy + a.z * cz;
    endfunction

    // n*65536 >= -tol*d, exact in 128 bits; d is already made positive
    function automatic bit within_tol(longint n, longint d);
        logic [127:0] lhs;
        logic [127:0] rhs;
        if (n >= 0)
            return 1'b1;
        lhs = {64'd0, 64'(-n)} << 16;
        rhs = {64'd0, 64'(d)} * {112'd0, tol_reg};
        return lhs <= rhs;
    endfunction

    function automatic verdict_t classify_point(logic [IN_DATA_W-1:0] pt);
        vec3_t    v0;
        vec3_t    v1;
        vec3_t    v2;
        vec3_t    v3;
        vec3_t    p;
        vec3_t    e1;
        vec3_t    e2;
        vec3_t    e3;
        vec3_t    q;
        longint   d;
        longint   nu;
        longint   nv;
        longint   nw;
        longint   n0;
        verdict_t r;
        v0 = vertex_of(vtx_reg[0]);
        v1 = vertex_of(vtx_reg[1]);
        v2 = vertex_of(vtx_reg[2]);
        v3 = vertex_of(vtx_reg[3]);
        p  = vertex_of(pt);
        e1 = vsub(v1, v0);
        e2 = vsub(v2, v0);
        e3 = vsub(v3, v0);
        q  = vsub(p, v0);
        d  = triple(e1, e2, e3);
        nu = triple(q, e2, e3);
        nv = triple(e1, q, e3);
        nw = triple(e1, e2, q);
        n0 = triple(vsub(v1, p), vsub(v2, p), vsub(v3, p));
        if (d < 0)
        begin
            d  = -d;
            nu = -nu;
            nv = -nv;
            nw = -nw;
            n0 = -n0;
        end
        r.degen  = 64'(d) <= {13'd0, limit_reg};
        r.in_tet = !r.degen && within_tol(nu, d) && within_tol(nv, d) &&
                   within_tol(nw, d) && within_tol(n0, d);
        r.volume = d[VOL_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [VERT_W-1:0] pack_xyz(logic [15:0] x, logic [15:0] y,
                                                   logic [15:0] z);
        return {z, y, x};
    endfunction

    function automatic logic [15:0] clamp16(longint v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    function automatic longint spread(int span);
        return longint'($urandom_range(2 * span)) - span;
    endfunction

    function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        row_t r;
        r = '{ROW_WRITE, idx, data, '0, 1'b0, '0};
        script.push_back(r);
    endfunction

    function automatic void add_point(logic [IN_DATA_W-1:0] pt, bit known, logic in_tet,
                                      logic degen, logic [VOL_W-1:0] volume);
        row_t r;
        r = '{ROW_POINT, '0, '0, pt, known, '{in_tet, degen, volume}};
        script.push_back(r);
    endfunction

    // lower valid and wait until the pipeline has emptied
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (STAGES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            pit_pkg::REG_VERTEX_ZERO, pit_pkg::REG_VERTEX_ONE,
            pit_pkg::REG_VERTEX_TWO, pit_pkg::REG_VERTEX_THREE:
                vtx_reg[idx[1:0]] = data[VERT_W-1:0];
            pit_pkg::REG_TOLERANCE:
                tol_reg = data[TOL_W-1:0];
            pit_pkg::REG_DEGEN_LIMIT:
                limit_reg = data[LIMIT_W-1:0];
            default:
                ;
        endcase
        writes_done++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_point(logic [IN_DATA_W-1:0] pt, bit known, verdict_t v);
        given_answers.push_back('{known, v});
        while ($urandom_range(99) < sender_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pt;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        points_sent++;
    endtask

    task automatic randomize_setup();
        int                 shape;
        int                 span;
        longint             cx;
        longint             cy;
        longint             cz;
        logic [63:0]        r64;
        logic [VERT_W-1:0]  word;
        logic [VERT_W-1:0]  first_word;
        logic [TOL_W-1:0]   tol;
        logic [LIMIT_W-1:0] vol;
        logic [LIMIT_W-1:0] lim;
        shape = $urandom_range(3);
        span  = (shape == 3) ? $urandom_range(1, 16000) : $urandom_range(1, 2000);
        cx    = spread(30000);
        cy    = spread(30000);
        cz    = spread(30000);
        first_word = '0;
        for (int i = 0; i < 4; i++)
        begin
            r64 = {$urandom(), $urandom()};
            if (shape == 0)
                word = r64[VERT_W-1:0];
            else
                word = pack_xyz(clamp16(cx + spread(span)), clamp16(cy + spread(span)),
                                clamp16(cz + spread(span)));
            // coplanar: repeat a vertex, or put some vertices on one z plane
            if (shape == 2 && i == 3)
                word = r64[63] ? first_word : pack_xyz(word[15:0], word[31:16], clamp16(cz));
            if (shape == 2 && r64[62])
                word[47:32] = clamp16(cz);
            if (i == 1)
                first_word = word;
            write_reg(pit_pkg::REG_VERTEX_ZERO + CFG_IDX_W'(i), {r64[50:48], word});
        end
        case ($urandom_range(3))
            0: tol = '0;
            1: tol = '1;
            2: tol = TOL_W'($urandom_range(2048));
            default: tol = TOL_W'($urandom());
        endcase
        write_reg(pit_pkg::REG_TOLERANCE, {35'($urandom()), tol});
        vol = classify_point('0).volume;
        case ($urandom_range(7))
            4: lim = vol;
            5: lim = (vol != 0) ? vol - LIMIT_W'(1) : '0;
            6: lim = LIMIT_MAX;
            7: lim = vol >> $urandom_range(1, 8);
            default: lim = '0;
        endcase
        write_reg(pit_pkg::REG_DEGEN_LIMIT, lim);
        if ($urandom_range(7) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                      CFG_DATA_W'({$urandom(), $urandom()}));
    endtask

    function automatic logic [IN_DATA_W-1:0] random_point();
        vec3_t       vv [4];
        longint      w [4];
        longint      wsum;
        longint      ax;
        longint      ay;
        longint      az;
        int          pick;
        int          sel;
        logic [63:0] r64;
        for (int i = 0; i < 4; i++)
            vv[i] = vertex_of(vtx_reg[i]);
        sel = $urandom_range(99);
        r64 = {$urandom(), $urandom()};
        if (sel < 40)
        begin
            // weighted blend of the vertices, jittered across the faces
            wsum = 0;
            ax = 0;
            ay = 0;
            az = 0;
            for (int i = 0; i < 4; i++)
            begin
                w[i] = longint'($urandom_range(255));
                wsum += w[i];
                ax += w[i] * vv[i].x;
                ay += w[i] * vv[i].y;
                az += w[i] * vv[i].z;
            end
            if (wsum == 0)
            begin
                wsum = 1;
                ax = vv[0].x;
                ay = vv[0].y;
                az = vv[0].z;
            end
            return pack_xyz(clamp16(ax / wsum + spread(2)), clamp16(ay / wsum + spread(2)),
                            clamp16(az / wsum + spread(2)));
        end
        if (sel < 55)
        begin
            pick = $urandom_range(3);
            if (r64[0])
                return pack_xyz(clamp16(vv[pick].x), clamp16(vv[pick].y),
                                clamp16(vv[pick].z));
            return pack_xyz(clamp16(vv[pick].x + spread(1)), clamp16(vv[pick].y + spread(1)),
                            clamp16(vv[pick].z + spread(1)));
        end
        return r64[IN_DATA_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls plus an occasional long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_seen != hold_toggle)
        begin
            hold_seen     <= hold_toggle;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        verdict_t got;
        verdict_t want;
        answer_t  ans;
        bit       moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                moved = 1'b1;
                ans = (given_answers.size() != 0) ? given_answers.pop_front() : '0;
                if (ans.known)
                    want = ans.v;
                else
                    want = classify_point(s_axis_tdata);
                expected_verdicts.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                moved = 1'b1;
                got.in_tet = m_axis_tdata[0];
                got.degen  = m_axis_tdata[1];
                got.volume = m_axis_tdata[52:2];
                inside_seen += got.in_tet;
                degen_seen  += got.degen;
                if (expected_verdicts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: inside=%0d degen=%0d vol=%0d",
                                 got.in_tet, got.degen, got.volume);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (got.in_tet !== want.in_tet || got.degen !== want.degen ||
                        got.volume !== want.volume)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected inside=%0d degen=%0d vol=%0d,",
                                      " got inside=%0d degen=%0d vol=%0d"},
                                     want.in_tet, want.degen, want.volume,
                                     got.in_tet, got.degen, got.volume);
                    end
                end
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    initial
    begin : watchdog
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("no item moved for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] mid;
        for (int i = 0; i < 4; i++)
            vtx_reg[i] = '0;
        tol_reg   = '0;
        limit_reg = '0;
        lo  = 16'h8000;
        hi  = 16'h7FFF;
        mid = 16'hC000;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: all vertices at the origin, volume zero
        add_point(pack_xyz(16'd0, 16'd0, 16'd0), 1'b1, 1'b0, 1'b1, '0);
        add_point(pack_xyz(hi, lo, 16'hFFFF), 1'b1, 1'b0, 1'b1, '0);
        // unit-axis tetrahedron, edge 1024; junk above bit 47 must be dropped
        add_write(pit_pkg::REG_VERTEX_ZERO, {3'b111, pack_xyz(16'd0, 16'd0, 16'd0)});
        add_write(pit_pkg::REG_VERTEX_ONE, {3'b101, pack_xyz(16'd1024, 16'd0, 16'd0)});
        add_write(pit_pkg::REG_VERTEX_TWO, CFG_DATA_W'(pack_xyz(16'd0, 16'd1024, 16'd0)));
        add_write(pit_pkg::REG_VERTEX_THREE, CFG_DATA_W'(pack_xyz(16'd0, 16'd0, 16'd1024)));
        add_write(pit_pkg::REG_TOLERANCE, {35'h7_FFFF_FFFF, 16'h0000});
        add_write(pit_pkg::REG_DEGEN_LIMIT, '0);
        add_point(pack_xyz(16'd256, 16'd256, 16'd256), 1'b1, 1'b1, 1'b0, UNIT_VOL);
        add_point(pack_xyz(16'd0, 16'd0, 16'd0), 1'b1, 1'b1, 1'b0, UNIT_VOL);
        add_point(pack_xyz(16'd1024, 16'd0, 16'd0), 1'b1, 1'b1, 1'b0, UNIT_VOL);
        // on the far face
        add_point(pack_xyz(16'd341, 16'd341, 16'd342), 1'b1, 1'b1, 1'b0, UNIT_VOL);
        add_point(pack_xyz(16'hFFFF, 16'd0, 16'd0), 1'b1, 1'b0, 1'b0, UNIT_VOL);
        add_point(pack_xyz(16'd512, 16'd512, 16'd1), 1'b1, 1'b0, 1'b0, UNIT_VOL);
        add_point(pack_xyz(hi, hi, hi), 1'b1, 1'b0, 1'b0, UNIT_VOL);
        add_point(pack_xyz(lo, lo, lo), 1'b1, 1'b0, 1'b0, UNIT_VOL);
        // widest tolerance
        add_write(pit_pkg::REG_TOLERANCE, CFG_DATA_W'(16'hFFFF));
        add_point(pack_xyz(16'hFFFF, 16'd0, 16'd0), 1'b0, 1'b0, 1'b0, '0);
        add_point(pack_xyz(16'd1500, 16'd0, 16'd0), 1'b0, 1'b0, 1'b0, '0);
        add_point(pack_xyz(lo, lo, lo), 1'b0, 1'b0, 1'b0, '0);
        // limit exactly at |D| is degenerate, one below is not
        add_write(pit_pkg::REG_DEGEN_LIMIT, UNIT_VOL);
        add_point(pack_xyz(16'd256, 16'd256, 16'd256), 1'b1, 1'b0, 1'b1, UNIT_VOL);
        add_write(pit_pkg::REG_DEGEN_LIMIT, UNIT_VOL - VOL_W'(1));
        add_write(pit_pkg::REG_TOLERANCE, '0);
        add_point(pack_xyz(16'd256, 16'd256, 16'd256), 1'b1, 1'b1, 1'b0, UNIT_VOL);
        // spare indexes change nothing
        add_write(REG_SPARE_LO, '1);
        add_write(REG_SPARE_HI, '1);
        add_point(pack_xyz(16'd256, 16'd256, 16'd256), 1'b1, 1'b1, 1'b0, UNIT_VOL);
        // corner tetrahedron spanning the full coordinate range
        add_write(pit_pkg::REG_VERTEX_ZERO, CFG_DATA_W'(pack_xyz(lo, lo, lo)));
        add_write(pit_pkg::REG_VERTEX_ONE, CFG_DATA_W'(pack_xyz(hi, lo, lo)));
        add_write(pit_pkg::REG_VERTEX_TWO, CFG_DATA_W'(pack_xyz(lo, hi, lo)));
        add_write(pit_pkg::REG_VERTEX_THREE, CFG_DATA_W'(pack_xyz(lo, lo, hi)));
        add_write(pit_pkg::REG_DEGEN_LIMIT, LIMIT_MAX);
        add_point(pack_xyz(mid, mid, mid), 1'b1, 1'b0, 1'b1, WIDE_VOL);
        add_write(pit_pkg::REG_DEGEN_LIMIT, '0);
        add_point(pack_xyz(mid, mid, mid), 1'b1, 1'b1, 1'b0, WIDE_VOL);
        add_point(pack_xyz(lo, lo, lo), 1'b1, 1'b1, 1'b0, WIDE_VOL);
        add_point(pack_xyz(hi, hi, hi), 1'b1, 1'b0, 1'b0, WIDE_VOL);
        // mirrored orientation gives a negative determinant
        add_write(pit_pkg::REG_VERTEX_ONE, CFG_DATA_W'(pack_xyz(lo, hi, lo)));
        add_write(pit_pkg::REG_VERTEX_TWO, CFG_DATA_W'(pack_xyz(hi, lo, lo)));
        add_point(pack_xyz(mid, mid, mid), 1'b1, 1'b1, 1'b0, WIDE_VOL);
        add_point(pack_xyz(16'd0, 16'd0, 16'd0), 1'b0, 1'b0, 1'b0, '0);
        // all four vertices on one plane
        add_write(pit_pkg::REG_VERTEX_THREE, CFG_DATA_W'(pack_xyz(16'd0, 16'd0, lo)));
        add_point(pack_xyz(mid, mid, lo), 1'b1, 1'b0, 1'b1, '0);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_WRITE)
                write_reg(script[i].idx, script[i].data);
            else
                send_point(script[i].pt, script[i].known, script[i].v);
        end
        drain();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    sender_idle = 0;
                    stall_pct  <= 0;
                end
                1:
                begin
                    sender_idle = 72;
                    stall_pct  <= 0;
                end
                2:
                begin
                    sender_idle = 0;
                    stall_pct  <= 72;
                end
                default:
                begin
                    sender_idle = 18;
                    stall_pct  <= 18;
                end
            endcase
            for (int batch = 0; batch < BATCHES; batch++)
            begin
                randomize_setup();
                // long output hold-off while the sender keeps pushing
                if (phase == 2 && batch == 0)
                    hold_toggle <= ~hold_toggle;
                for (int n = 0; n < BATCH_ITEMS; n++)
                begin
                    if (phase == 5 && batch == 2 && n == BATCH_ITEMS / 2)
                        drain();
                    send_point(random_point(), 1'b0, '0);
                end
            end
        end

        drain();
        $display("Sent %0d point items across %0d register writes and %0d setups.",
                 points_sent, writes_done, PHASES * BATCHES + 6);
        $display("Results: %0d inside, %0d degenerate, %0d mismatches.",
                 inside_seen, degen_seen, mismatches);
        if (mismatches == 0 && expected_verdicts.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pit_pkg.sv
rtl/pit_cross.sv
rtl/point_in_tetrahedron_test.sv
dv/testbench.sv
